// ----- hdl/xrmp_pkg.sv -----
// ---------------------------------------------------------------------------
// xrmp_pkg
// Shared types, constants and opcode lookup functions for the real-mode
// instruction predecoder.
// ---------------------------------------------------------------------------
`default_nettype none

package xrmp_pkg;

    // Records longer than this are cut short (range 6..15)
    localparam logic [3:0] MAX_LENGTH = 4'd15;

    // Prefix and opcode bytes
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] PFX_ADSIZE = 8'h67;
    localparam logic [7:0] PFX_LOCK   = 8'hF0;
    localparam logic [7:0] PFX_REP    = 8'hF3;
    localparam logic [7:0] PFX_REPNE  = 8'hF2;
    localparam logic [7:0] PFX_ES     = 8'h26;
    localparam logic [7:0] PFX_CS     = 8'h2E;
    localparam logic [7:0] PFX_SS     = 8'h36;
    localparam logic [7:0] PFX_DS     = 8'h3E;
    localparam logic [7:0] PFX_FS     = 8'h64;
    localparam logic [7:0] PFX_GS     = 8'h65;
    localparam logic [7:0] OP_GRP5    = 8'hFF;

    // Mnemonic classes
    localparam logic [5:0] MN_INT3      = 6'd0;
    localparam logic [5:0] MN_INT       = 6'd1;
    localparam logic [5:0] MN_INTO      = 6'd2;
    localparam logic [5:0] MN_IRET      = 6'd3;
    localparam logic [5:0] MN_CLI       = 6'd4;
    localparam logic [5:0] MN_STI       = 6'd5;
    localparam logic [5:0] MN_HLT       = 6'd6;
    localparam logic [5:0] MN_NOP       = 6'd7;
    localparam logic [5:0] MN_CLC       = 6'd8;
    localparam logic [5:0] MN_STC       = 6'd9;
    localparam logic [5:0] MN_CLD       = 6'd10;
    localparam logic [5:0] MN_STD       = 6'd11;
    localparam logic [5:0] MN_PUSHF     = 6'd12;
    localparam logic [5:0] MN_POPF      = 6'd13;
    localparam logic [5:0] MN_RET       = 6'd14;
    localparam logic [5:0] MN_RET_IMM   = 6'd15;
    localparam logic [5:0] MN_RETF      = 6'd16;
    localparam logic [5:0] MN_RETF_IMM  = 6'd17;
    localparam logic [5:0] MN_CALL_REL  = 6'd18;
    localparam logic [5:0] MN_CALL_FAR  = 6'd19;
    localparam logic [5:0] MN_JMP_REL   = 6'd20;
    localparam logic [5:0] MN_JMP_SHORT = 6'd21;
    localparam logic [5:0] MN_JMP_FAR   = 6'd22;
    localparam logic [5:0] MN_JCC       = 6'd23;
    localparam logic [5:0] MN_LOOPNZ    = 6'd24;
    localparam logic [5:0] MN_LOOPZ     = 6'd25;
    localparam logic [5:0] MN_LOOP      = 6'd26;
    localparam logic [5:0] MN_JCXZ      = 6'd27;
    localparam logic [5:0] MN_IN_AL_I   = 6'd28;
    localparam logic [5:0] MN_IN_AX_I   = 6'd29;
    localparam logic [5:0] MN_OUT_I_AL  = 6'd30;
    localparam logic [5:0] MN_OUT_I_AX  = 6'd31;
    localparam logic [5:0] MN_IN_AL_DX  = 6'd32;
    localparam logic [5:0] MN_IN_AX_DX  = 6'd33;
    localparam logic [5:0] MN_OUT_DX_AL = 6'd34;
    localparam logic [5:0] MN_OUT_DX_AX = 6'd35;
    localparam logic [5:0] MN_INSB      = 6'd36;
    localparam logic [5:0] MN_INSW      = 6'd37;
    localparam logic [5:0] MN_OUTSB     = 6'd38;
    localparam logic [5:0] MN_OUTSW     = 6'd39;
    localparam logic [5:0] MN_PUSH_R    = 6'd40;
    localparam logic [5:0] MN_POP_R     = 6'd41;
    localparam logic [5:0] MN_MOV_R8    = 6'd42;
    localparam logic [5:0] MN_MOV_R16   = 6'd43;
    localparam logic [5:0] MN_GRP_OTHER = 6'd49;
    localparam logic [5:0] MN_XCHG_AX   = 6'd50;
    localparam logic [5:0] MN_CBW       = 6'd51;
    localparam logic [5:0] MN_CWD       = 6'd52;
    localparam logic [5:0] MN_UNKNOWN   = 6'd63;

    typedef struct packed {
        logic [5:0]  mnemonic_id;
        logic        rep_seen;
        logic        repne_seen;
        logic        wide_operands;
        logic [3:0]  reg_index;
        logic [31:0] operand_value;
        logic [15:0] segment_value;
        logic [15:0] branch_target;
        logic [3:0]  length;
        logic        overlength;
    } rec_t;

    function automatic logic is_prefix(input logic [7:0] b);
        is_prefix = (b == PFX_OPSIZE) || (b == PFX_REP) || (b == PFX_REPNE) ||
                    (b == PFX_ADSIZE) || (b == PFX_LOCK) || (b == PFX_ES) ||
                    (b == PFX_CS) || (b == PFX_SS) || (b == PFX_DS) ||
                    (b == PFX_FS) || (b == PFX_GS);
    endfunction

    // Operand bytes following a non-FF opcode
    function automatic logic [2:0] operand_len(input logic [7:0] op, input logic wide);
        logic [2:0] n;
        n = 3'd0;
        if (op[7:4] == 4'h7 || op[7:3] == 5'b10110 || op[7:3] == 5'b11100 ||
            op == 8'hCD || op == 8'hEB)
            n = 3'd1;
        else if (op[7:3] == 5'b10111)
            n = wide ? 3'd4 : 3'd2;
        else if (op == 8'hC2 || op == 8'hCA || op == 8'hE8 || op == 8'hE9)
            n = 3'd2;
        else if (op == 8'h9A || op == 8'hEA)
            n = 3'd4;
        operand_len = n;
    endfunction

    // Displacement bytes following a ModRM byte
    function automatic logic [2:0] disp_len(input logic [7:0] modrm);
        logic [2:0] n;
        n = 3'd0;
        case (modrm[7:6])
            2'd1:    n = 3'd1;
            2'd2:    n = 3'd2;
            2'd0:    n = (modrm[2:0] == 3'd6) ? 3'd2 : 3'd0;
            default: n = 3'd0;
        endcase
        disp_len = n;
    endfunction

    function automatic logic [5:0] op_class(input logic [7:0] op, input logic [7:0] modrm);
        logic [5:0] c;
        c = MN_UNKNOWN;
        if (op[7:4] == 4'h7)                       c = MN_JCC;
        else if (op[7:3] == 5'b01010)              c = MN_PUSH_R;
        else if (op[7:3] == 5'b01011)              c = MN_POP_R;
        else if (op[7:3] == 5'b10110)              c = MN_MOV_R8;
        else if (op[7:3] == 5'b10111)              c = MN_MOV_R16;
        else if (op[7:3] == 5'b10010 && op != 8'h90) c = MN_XCHG_AX;
        else begin
            case (op)
                8'hCC: c = MN_INT3;      8'hCD: c = MN_INT;
                8'hCE: c = MN_INTO;      8'hCF: c = MN_IRET;
                8'hFA: c = MN_CLI;       8'hFB: c = MN_STI;
                8'hF4: c = MN_HLT;       8'h90: c = MN_NOP;
                8'hF8: c = MN_CLC;       8'hF9: c = MN_STC;
                8'hFC: c = MN_CLD;       8'hFD: c = MN_STD;
                8'h9C: c = MN_PUSHF;     8'h9D: c = MN_POPF;
                8'hC3: c = MN_RET;       8'hC2: c = MN_RET_IMM;
                8'hCB: c = MN_RETF;      8'hCA: c = MN_RETF_IMM;
                8'hE8: c = MN_CALL_REL;  8'h9A: c = MN_CALL_FAR;
                8'hE9: c = MN_JMP_REL;   8'hEB: c = MN_JMP_SHORT;
                8'hEA: c = MN_JMP_FAR;   8'hE0: c = MN_LOOPNZ;
                8'hE1: c = MN_LOOPZ;     8'hE2: c = MN_LOOP;
                8'hE3: c = MN_JCXZ;      8'hE4: c = MN_IN_AL_I;
                8'hE5: c = MN_IN_AX_I;   8'hE6: c = MN_OUT_I_AL;
                8'hE7: c = MN_OUT_I_AX;  8'hEC: c = MN_IN_AL_DX;
                8'hED: c = MN_IN_AX_DX;  8'hEE: c = MN_OUT_DX_AL;
                8'hEF: c = MN_OUT_DX_AX; 8'h6C: c = MN_INSB;
                8'h6D: c = MN_INSW;      8'h6E: c = MN_OUTSB;
                8'h6F: c = MN_OUTSW;     8'h98: c = MN_CBW;
                8'h99: c = MN_CWD;
                8'hFF: begin
                    // reg 2..6 map onto classes 44..48
                    if (modrm[5:3] >= 3'd2 && modrm[5:3] <= 3'd6)
                        c = 6'(7'd42 + {4'd0, modrm[5:3]});
                    else
                        c = MN_GRP_OTHER;
                end
                default: c = MN_UNKNOWN;
            endcase
        end
        op_class = c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/xrmp_in_if.sv -----
// ---------------------------------------------------------------------------
// xrmp_in_if
// Code byte channel: one byte per request, with a start-of-instruction mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface xrmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       start_flag;

    modport source (output valid, output code_byte, output start_flag, input ready);
    modport sink   (input valid, input code_byte, input start_flag, output ready);
endinterface

`default_nettype wire

// ----- hdl/xrmp_out_if.sv -----
// ---------------------------------------------------------------------------
// xrmp_out_if
// Decoded record channel: one instruction record per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface xrmp_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  mnemonic_id;
    logic        rep_seen;
    logic        repne_seen;
    logic        wide_operands;
    logic [3:0]  reg_index;
    logic [31:0] operand_value;
    logic [15:0] segment_value;
    logic [15:0] branch_target;
    logic [3:0]  length;
    logic        overlength;

    modport source (output valid, output mnemonic_id, output rep_seen, output repne_seen,
                    output wide_operands, output reg_index, output operand_value,
                    output segment_value, output branch_target, output length,
                    output overlength, input ready);
    modport sink   (input valid, input mnemonic_id, input rep_seen, input repne_seen,
                    input wide_operands, input reg_index, input operand_value,
                    input segment_value, input branch_target, input length,
                    input overlength, output ready);
endinterface

`default_nettype wire

// ----- hdl/x86_real_mode_instruction_predecoder_unit.sv -----
// ---------------------------------------------------------------------------
// x86_real_mode_instruction_predecoder_unit
// Byte-serial 16-bit x86 predecoder: gathers prefixes, opcode, ModRM and
// operand bytes and emits one record per instruction.
// ---------------------------------------------------------------------------
//  Channel    | Dir | Request carries
//  -----------+-----+-------------------------------------------------------
//  code_ch    | in  | code_byte, start_flag
//  record_ch  | out | decoded record (class, prefix marks, operand, target...)
//
//  One code byte per cycle sustained while no record stalls; a record is
//  offered once its last byte has passed the byte and record registers.
//  The per-byte decode sits between the byte register and the record
//  register; decoder state updates when the byte leaves the byte register.
//  A stalled record only blocks bytes that would produce another record.
//  Reset (rst_n low) drops any partial instruction and pending record.
`default_nettype none

module x86_real_mode_instruction_predecoder_unit (
    input  wire           clk,
    input  wire           rst_n,
    xrmp_in_if.sink       code_ch,
    xrmp_out_if.source    record_ch
);

    localparam logic [1:0] PH_PREFIX   = 2'd0;
    localparam logic [1:0] PH_MODRM    = 2'd1;
    localparam logic [1:0] PH_OPERANDS = 2'd2;

    // byte register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;

    // decoder state
    logic [3:0]  cnt_reg,    cnt_next;
    logic [1:0]  phase_reg,  phase_next;
    logic [2:0]  marks_reg,  marks_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg,  modrm_next;
    logic [2:0]  remain_reg, remain_next;
    logic [31:0] accum_reg,  accum_next;

    // record register
    logic              out_valid_reg;
    xrmp_pkg::rec_t    out_rec_reg;

    // working values after this byte
    logic [3:0]  w_cnt;
    logic [1:0]  w_phase;
    logic [2:0]  w_marks;
    logic [7:0]  w_op;
    logic [7:0]  w_modrm;
    logic [2:0]  w_remain;
    logic [31:0] w_accum;
    logic [2:0]  total;
    logic [1:0]  idx;
    logic        done;
    logic        over;
    logic        emit;
    logic        out_free;
    logic        s1_adv;
    logic [7:0]  b;
    xrmp_pkg::rec_t rec;

    assign b        = s1_byte_reg;
    assign out_free = !out_valid_reg || record_ch.ready;
    assign s1_adv   = s1_valid_reg && (!emit || out_free);
    assign code_ch.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        // start_flag drops the partial instruction first
        if (s1_start_reg)
        begin
            w_cnt = 4'd0; w_phase = PH_PREFIX; w_marks = 3'd0; w_op = 8'd0;
            w_modrm = 8'd0; w_remain = 3'd0; w_accum = 32'd0;
        end
        else
        begin
            w_cnt = cnt_reg; w_phase = phase_reg; w_marks = marks_reg; w_op = opcode_reg;
            w_modrm = modrm_reg; w_remain = remain_reg; w_accum = accum_reg;
        end
        w_cnt = w_cnt + 4'd1;
        done  = 1'b0;
        total = (w_op == xrmp_pkg::OP_GRP5) ? xrmp_pkg::disp_len(w_modrm)
                                            : xrmp_pkg::operand_len(w_op, w_marks[2]);
        idx   = 2'(total - w_remain);

        case (w_phase)
            PH_PREFIX:
            begin
                if (b == xrmp_pkg::PFX_OPSIZE)
                    w_marks[2] = 1'b1;
                else if (b == xrmp_pkg::PFX_REP)
                    w_marks[0] = 1'b1;
                else if (b == xrmp_pkg::PFX_REPNE)
                    w_marks[1] = 1'b1;
                else if (!xrmp_pkg::is_prefix(b))
                begin
                    w_op = b;
                    if (b == xrmp_pkg::OP_GRP5)
                        w_phase = PH_MODRM;
                    else
                    begin
                        w_phase  = PH_OPERANDS;
                        w_remain = xrmp_pkg::operand_len(b, w_marks[2]);
                        done     = (w_remain == 3'd0);
                    end
                end
            end
            PH_MODRM:
            begin
                w_modrm  = b;
                w_phase  = PH_OPERANDS;
                w_remain = xrmp_pkg::disp_len(b);
                done     = (w_remain == 3'd0);
            end
            default:
            begin
                // at most four operand bytes, little-endian
                case (idx)
                    2'd0:    w_accum[7:0]   = w_accum[7:0]   | b;
                    2'd1:    w_accum[15:8]  = w_accum[15:8]  | b;
                    2'd2:    w_accum[23:16] = w_accum[23:16] | b;
                    default: w_accum[31:24] = w_accum[31:24] | b;
                endcase
                if (w_remain != 3'd0)
                    w_remain = w_remain - 3'd1;
                done = (w_remain == 3'd0);
            end
        endcase

        over = !done && (w_cnt >= xrmp_pkg::MAX_LENGTH);
        emit = done || over;
    end

    // record build from the post-byte state
    always_comb
    begin
        rec               = '0;
        rec.mnemonic_id   = xrmp_pkg::MN_UNKNOWN;
        rec.rep_seen      = w_marks[0];
        rec.repne_seen    = w_marks[1];
        rec.wide_operands = w_marks[2];
        rec.length        = w_cnt;
        rec.overlength    = over;
        if (w_phase != PH_PREFIX)
        begin
            rec.mnemonic_id   = xrmp_pkg::op_class(w_op, w_modrm);
            rec.operand_value = w_accum;
            if (rec.mnemonic_id == xrmp_pkg::MN_UNKNOWN)
                rec.operand_value = {24'd0, w_op};
            else if (rec.mnemonic_id == xrmp_pkg::MN_JCC)
                rec.reg_index = w_op[3:0];
            else if (rec.mnemonic_id == xrmp_pkg::MN_PUSH_R ||
                     rec.mnemonic_id == xrmp_pkg::MN_POP_R ||
                     rec.mnemonic_id == xrmp_pkg::MN_MOV_R8 ||
                     rec.mnemonic_id == xrmp_pkg::MN_MOV_R16 ||
                     rec.mnemonic_id == xrmp_pkg::MN_XCHG_AX)
                rec.reg_index = {1'b0, w_op[2:0]};
            else if (w_op == xrmp_pkg::OP_GRP5)
                rec.reg_index = {1'b0, w_modrm[5:3]};
            else if (rec.mnemonic_id == xrmp_pkg::MN_CALL_FAR ||
                     rec.mnemonic_id == xrmp_pkg::MN_JMP_FAR)
            begin
                rec.operand_value = {16'd0, w_accum[15:0]};
                rec.segment_value = w_accum[31:16];
            end

            if (rec.mnemonic_id == xrmp_pkg::MN_JMP_SHORT ||
                rec.mnemonic_id == xrmp_pkg::MN_JCC ||
                rec.mnemonic_id == xrmp_pkg::MN_LOOPNZ ||
                rec.mnemonic_id == xrmp_pkg::MN_LOOPZ ||
                rec.mnemonic_id == xrmp_pkg::MN_LOOP ||
                rec.mnemonic_id == xrmp_pkg::MN_JCXZ)
                rec.branch_target = {12'd0, w_cnt} + {{8{w_accum[7]}}, w_accum[7:0]};
            else if (rec.mnemonic_id == xrmp_pkg::MN_CALL_REL ||
                     rec.mnemonic_id == xrmp_pkg::MN_JMP_REL)
                rec.branch_target = {12'd0, w_cnt} + w_accum[15:0];
        end
    end

    always_comb
    begin
        if (emit)
        begin
            cnt_next = 4'd0; phase_next = PH_PREFIX; marks_next = 3'd0; opcode_next = 8'd0;
            modrm_next = 8'd0; remain_next = 3'd0; accum_next = 32'd0;
        end
        else
        begin
            cnt_next = w_cnt; phase_next = w_phase; marks_next = w_marks; opcode_next = w_op;
            modrm_next = w_modrm; remain_next = w_remain; accum_next = w_accum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (code_ch.valid && code_ch.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_ch.valid && code_ch.ready)
        begin
            s1_byte_reg  <= code_ch.code_byte;
            s1_start_reg <= code_ch.start_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 4'd0;
            phase_reg  <= PH_PREFIX;
            marks_reg  <= 3'd0;
            opcode_reg <= 8'd0;
            modrm_reg  <= 8'd0;
            remain_reg <= 3'd0;
            accum_reg  <= 32'd0;
        end
        else if (s1_adv)
        begin
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
            marks_reg  <= marks_next;
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            remain_reg <= remain_next;
            accum_reg  <= accum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (record_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            out_rec_reg <= rec;
        end
    end

    assign record_ch.valid         = out_valid_reg;
    assign record_ch.mnemonic_id   = out_rec_reg.mnemonic_id;
    assign record_ch.rep_seen      = out_rec_reg.rep_seen;
    assign record_ch.repne_seen    = out_rec_reg.repne_seen;
    assign record_ch.wide_operands = out_rec_reg.wide_operands;
    assign record_ch.reg_index     = out_rec_reg.reg_index;
    assign record_ch.operand_value = out_rec_reg.operand_value;
    assign record_ch.segment_value = out_rec_reg.segment_value;
    assign record_ch.branch_target = out_rec_reg.branch_target;
    assign record_ch.length        = out_rec_reg.length;
    assign record_ch.overlength    = out_rec_reg.overlength;

endmodule

`default_nettype wire

// ----- hdl/xrmp_checker.sv -----
// ---------------------------------------------------------------------------
// xrmp_checker
// Port-level checks on the predecoder's record channel.
// ---------------------------------------------------------------------------
`default_nettype none

module xrmp_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        rec_valid,
    input wire        rec_ready,
    input wire [5:0]  mnemonic_id,
    input wire [15:0] segment_value,
    input wire [3:0]  length,
    input wire        overlength
);

    // a stalled record stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid)
        else $error("record dropped while stalled");

    // every record consumed at least one byte
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> length != 4'd0)
        else $error("record with zero length");

    // a cut-short record is exactly the length limit
    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && overlength |-> length == xrmp_pkg::MAX_LENGTH)
        else $error("overlength record with wrong length");

    // only direct far transfers carry a segment
    a_seg: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && segment_value != 16'd0 |->
            mnemonic_id == xrmp_pkg::MN_CALL_FAR || mnemonic_id == xrmp_pkg::MN_JMP_FAR)
        else $error("segment on non-far record");

endmodule

bind x86_real_mode_instruction_predecoder_unit xrmp_checker u_xrmp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (record_ch.valid),
    .rec_ready     (record_ch.ready),
    .mnemonic_id   (record_ch.mnemonic_id),
    .segment_value (record_ch.segment_value),
    .length        (record_ch.length),
    .overlength    (record_ch.overlength)
);

`default_nettype wire

// ----- bench/x86_real_mode_instruction_predecoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// x86_real_mode_instruction_predecoder_unit_tb
// Streams code bytes into the predecoder and checks every decoded record
// against a cycle-free decoder model kept in the bench. Directed rows cover
// the prefix marks, the length limit, restarts and operand extremes; random
// instruction streams follow under three idle mixes and one long output stall.
// ---------------------------------------------------------------------------

module x86_real_mode_instruction_predecoder_unit_tb;

    // FF group classes that the package has no names for
    localparam logic [5:0] MN_CALL_MEM  = 6'd44;
    localparam logic [5:0] MN_CALLF_MEM = 6'd45;
    localparam logic [5:0] MN_JMP_MEM   = 6'd46;
    localparam logic [5:0] MN_JMPF_MEM  = 6'd47;
    localparam logic [5:0] MN_PUSH_MEM  = 6'd48;

    // Opcodes used in the directed rows
    localparam logic [7:0] OPC_INSB    = 8'h6C;
    localparam logic [7:0] OPC_MOV_AX  = 8'hB8;
    localparam logic [7:0] OPC_JMP_FAR = 8'hEA;
    localparam logic [7:0] MODRM_CALL  = 8'hD7;   // mod 3, reg 2, rm 7

    localparam int HOLD_CYCLES = 200;

    typedef enum logic [1:0] {AWAIT_LEAD, AWAIT_MODRM, AWAIT_OPND} dec_phase_e;

    typedef struct {
        logic [7:0]     cb;
        logic           st;
        logic           use_typed;
        xrmp_pkg::rec_t rec;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    xrmp_in_if  in_ch ();
    xrmp_out_if out_ch ();

    x86_real_mode_instruction_predecoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .code_ch   (in_ch),
        .record_ch (out_ch)
    );

    always #4 clk = ~clk;

    // decoder model state
    logic [3:0]  dec_count;
    dec_phase_e  dec_phase;
    logic [2:0]  dec_marks;     // bit0 F3, bit1 F2, bit2 66
    logic [7:0]  dec_op;
    logic [7:0]  dec_modrm;
    logic [2:0]  dec_left;
    logic [47:0] dec_accum;

    xrmp_pkg::rec_t pending_records[$];
    stim_row_t      directed_rows[$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    logic        restart_next = 1'b0;
    logic        hold_go = 1'b0;
    logic        rx_hold = 1'b0;

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.code_byte  = 8'h00;
        in_ch.start_flag = 1'b0;
        out_ch.ready     = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic int imm_bytes(input logic [7:0] op, input logic wide);
        int n;
        n = 0;
        if ((op >= 8'h70 && op <= 8'h7F) || (op >= 8'hB0 && op <= 8'hB7) ||
            (op >= 8'hE0 && op <= 8'hE7) || op == 8'hCD || op == 8'hEB)
            n = 1;
        else if (op >= 8'hB8 && op <= 8'hBF)
            n = wide ? 4 : 2;
        else if (op == 8'hC2 || op == 8'hCA || op == 8'hE8 || op == 8'hE9)
            n = 2;
        else if (op == 8'h9A || op == 8'hEA)
            n = 4;
        return n;
    endfunction

    function automatic int disp_bytes(input logic [7:0] modrm);
        int n;
        n = 0;
        if (modrm[7:6] == 2'd1)
            n = 1;
        else if (modrm[7:6] == 2'd2 || (modrm[7:6] == 2'd0 && modrm[2:0] == 3'd6))
            n = 2;
        return n;
    endfunction

    function automatic logic [5:0] insn_class(input logic [7:0] op, input logic [7:0] modrm);
        logic [5:0] c;
        case (op)
            8'hCC: c = xrmp_pkg::MN_INT3;       8'hCD: c = xrmp_pkg::MN_INT;
            8'hCE: c = xrmp_pkg::MN_INTO;       8'hCF: c = xrmp_pkg::MN_IRET;
            8'hFA: c = xrmp_pkg::MN_CLI;        8'hFB: c = xrmp_pkg::MN_STI;
            8'hF4: c = xrmp_pkg::MN_HLT;        8'h90: c = xrmp_pkg::MN_NOP;
            8'hF8: c = xrmp_pkg::MN_CLC;        8'hF9: c = xrmp_pkg::MN_STC;
            8'hFC: c = xrmp_pkg::MN_CLD;        8'hFD: c = xrmp_pkg::MN_STD;
            8'h9C: c = xrmp_pkg::MN_PUSHF;      8'h9D: c = xrmp_pkg::MN_POPF;
            8'hC3: c = xrmp_pkg::MN_RET;        8'hC2: c = xrmp_pkg::MN_RET_IMM;
            8'hCB: c = xrmp_pkg::MN_RETF;       8'hCA: c = xrmp_pkg::MN_RETF_IMM;
            8'hE8: c = xrmp_pkg::MN_CALL_REL;   8'h9A: c = xrmp_pkg::MN_CALL_FAR;
            8'hE9: c = xrmp_pkg::MN_JMP_REL;    8'hEB: c = xrmp_pkg::MN_JMP_SHORT;
            8'hEA: c = xrmp_pkg::MN_JMP_FAR;    8'hE0: c = xrmp_pkg::MN_LOOPNZ;
            8'hE1: c = xrmp_pkg::MN_LOOPZ;      8'hE2: c = xrmp_pkg::MN_LOOP;
            8'hE3: c = xrmp_pkg::MN_JCXZ;       8'hE4: c = xrmp_pkg::MN_IN_AL_I;
            8'hE5: c = xrmp_pkg::MN_IN_AX_I;    8'hE6: c = xrmp_pkg::MN_OUT_I_AL;
            8'hE7: c = xrmp_pkg::MN_OUT_I_AX;   8'hEC: c = xrmp_pkg::MN_IN_AL_DX;
            8'hED: c = xrmp_pkg::MN_IN_AX_DX;   8'hEE: c = xrmp_pkg::MN_OUT_DX_AL;
            8'hEF: c = xrmp_pkg::MN_OUT_DX_AX;  8'h6C: c = xrmp_pkg::MN_INSB;
            8'h6D: c = xrmp_pkg::MN_INSW;       8'h6E: c = xrmp_pkg::MN_OUTSB;
            8'h6F: c = xrmp_pkg::MN_OUTSW;      8'h98: c = xrmp_pkg::MN_CBW;
            8'h99: c = xrmp_pkg::MN_CWD;
            8'hFF:
            begin
                case (modrm[5:3])
                    3'd2:    c = MN_CALL_MEM;
                    3'd3:    c = MN_CALLF_MEM;
                    3'd4:    c = MN_JMP_MEM;
                    3'd5:    c = MN_JMPF_MEM;
                    3'd6:    c = MN_PUSH_MEM;
                    default: c = xrmp_pkg::MN_GRP_OTHER;
                endcase
            end
            default: c = xrmp_pkg::MN_UNKNOWN;
        endcase
        if (op >= 8'h70 && op <= 8'h7F)      c = xrmp_pkg::MN_JCC;
        else if (op >= 8'h50 && op <= 8'h57) c = xrmp_pkg::MN_PUSH_R;
        else if (op >= 8'h58 && op <= 8'h5F) c = xrmp_pkg::MN_POP_R;
        else if (op >= 8'hB0 && op <= 8'hB7) c = xrmp_pkg::MN_MOV_R8;
        else if (op >= 8'hB8 && op <= 8'hBF) c = xrmp_pkg::MN_MOV_R16;
        else if (op >= 8'h91 && op <= 8'h97) c = xrmp_pkg::MN_XCHG_AX;
        return c;
    endfunction

    function automatic logic is_silent_prefix(input logic [7:0] b);
        return b == xrmp_pkg::PFX_ADSIZE || b == xrmp_pkg::PFX_LOCK ||
               b == xrmp_pkg::PFX_ES || b == xrmp_pkg::PFX_CS ||
               b == xrmp_pkg::PFX_SS || b == xrmp_pkg::PFX_DS ||
               b == xrmp_pkg::PFX_FS || b == xrmp_pkg::PFX_GS;
    endfunction

    function automatic void clear_decoder();
        dec_count = 4'd0;
        dec_phase = AWAIT_LEAD;
        dec_marks = 3'd0;
        dec_op    = 8'h00;
        dec_modrm = 8'h00;
        dec_left  = 3'd0;
        dec_accum = 48'd0;
    endfunction

    function automatic xrmp_pkg::rec_t build_record(input logic over);
        xrmp_pkg::rec_t r;
        logic [5:0] mn;
        r  = '0;
        mn = xrmp_pkg::MN_UNKNOWN;
        if (dec_phase != AWAIT_LEAD)
        begin
            mn = insn_class(dec_op, dec_modrm);
            r.operand_value = dec_accum[31:0];
            if (mn == xrmp_pkg::MN_UNKNOWN)
                r.operand_value = {24'd0, dec_op};
            else if (mn == xrmp_pkg::MN_JCC)
                r.reg_index = dec_op[3:0];
            else if (mn == xrmp_pkg::MN_PUSH_R || mn == xrmp_pkg::MN_POP_R ||
                     mn == xrmp_pkg::MN_MOV_R8 || mn == xrmp_pkg::MN_MOV_R16 ||
                     mn == xrmp_pkg::MN_XCHG_AX)
                r.reg_index = {1'b0, dec_op[2:0]};
            else if (dec_op == xrmp_pkg::OP_GRP5)
                r.reg_index = {1'b0, dec_modrm[5:3]};
            else if (mn == xrmp_pkg::MN_CALL_FAR || mn == xrmp_pkg::MN_JMP_FAR)
            begin
                r.operand_value = {16'd0, dec_accum[15:0]};
                r.segment_value = dec_accum[31:16];
            end
            // targets are relative to the start of the instruction
            if (mn == xrmp_pkg::MN_JMP_SHORT || mn == xrmp_pkg::MN_JCC ||
                mn == xrmp_pkg::MN_LOOPNZ || mn == xrmp_pkg::MN_LOOPZ ||
                mn == xrmp_pkg::MN_LOOP || mn == xrmp_pkg::MN_JCXZ)
                r.branch_target = {12'd0, dec_count} + {{8{dec_accum[7]}}, dec_accum[7:0]};
            else if (mn == xrmp_pkg::MN_CALL_REL || mn == xrmp_pkg::MN_JMP_REL)
                r.branch_target = {12'd0, dec_count} + dec_accum[15:0];
        end
        r.mnemonic_id   = mn;
        r.rep_seen      = dec_marks[0];
        r.repne_seen    = dec_marks[1];
        r.wide_operands = dec_marks[2];
        r.length        = dec_count;
        r.overlength    = over;
        return r;
    endfunction

    // Advance the model by one accepted code byte
    task automatic predecode_byte(input logic [7:0] cb, input logic st,
                                  output logic fired, output xrmp_pkg::rec_t r);
        logic wide;
        logic done;
        int   total;
        int   idx;
        fired = 1'b0;
        done  = 1'b0;
        r     = '0;
        if (st)
            clear_decoder();
        dec_count = dec_count + 4'd1;
        wide = dec_marks[2];
        case (dec_phase)
            AWAIT_LEAD:
            begin
                if (cb == xrmp_pkg::PFX_OPSIZE)
                    dec_marks[2] = 1'b1;
                else if (cb == xrmp_pkg::PFX_REP)
                    dec_marks[0] = 1'b1;
                else if (cb == xrmp_pkg::PFX_REPNE)
                    dec_marks[1] = 1'b1;
                else if (!is_silent_prefix(cb))
                begin
                    dec_op = cb;
                    if (cb == xrmp_pkg::OP_GRP5)
                        dec_phase = AWAIT_MODRM;
                    else
                    begin
                        dec_phase = AWAIT_OPND;
                        dec_left  = 3'(imm_bytes(cb, wide));
                        done      = (dec_left == 3'd0);
                    end
                end
            end
            AWAIT_MODRM:
            begin
                dec_modrm = cb;
                dec_phase = AWAIT_OPND;
                dec_left  = 3'(disp_bytes(cb));
                done      = (dec_left == 3'd0);
            end
            default:
            begin
                total = (dec_op == xrmp_pkg::OP_GRP5) ? disp_bytes(dec_modrm)
                                                       : imm_bytes(dec_op, wide);
                idx   = total - int'(dec_left);
                if (idx >= 0 && idx < 6)
                    dec_accum = dec_accum | (48'(cb) << (8 * idx));
                if (dec_left != 3'd0)
                    dec_left = dec_left - 3'd1;
                done = (dec_left == 3'd0);
            end
        endcase
        if (done || dec_count >= xrmp_pkg::MAX_LENGTH)
        begin
            r     = build_record(!done);
            fired = 1'b1;
            clear_decoder();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] prefix_by_index(input int i);
        logic [7:0] p;
        case (i)
            0:       p = xrmp_pkg::PFX_OPSIZE;
            1:       p = xrmp_pkg::PFX_REP;
            2:       p = xrmp_pkg::PFX_REPNE;
            3:       p = xrmp_pkg::PFX_ADSIZE;
            4:       p = xrmp_pkg::PFX_LOCK;
            5:       p = xrmp_pkg::PFX_ES;
            6:       p = xrmp_pkg::PFX_CS;
            7:       p = xrmp_pkg::PFX_SS;
            8:       p = xrmp_pkg::PFX_DS;
            9:       p = xrmp_pkg::PFX_FS;
            default: p = xrmp_pkg::PFX_GS;
        endcase
        return p;
    endfunction

    function automatic xrmp_pkg::rec_t mk_rec(input logic [5:0] mn, input logic [2:0] marks,
                                              input logic [3:0] len, input logic over);
        xrmp_pkg::rec_t r;
        r = '0;
        r.mnemonic_id   = mn;
        r.rep_seen      = marks[0];
        r.repne_seen    = marks[1];
        r.wide_operands = marks[2];
        r.length        = len;
        r.overlength    = over;
        return r;
    endfunction

    task automatic add_row(input logic [7:0] cb, input logic st,
                           input logic use_typed, input xrmp_pkg::rec_t rec);
        stim_row_t row;
        row.cb        = cb;
        row.st        = st;
        row.use_typed = use_typed;
        row.rec       = rec;
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic push_byte(input logic [7:0] cb, input logic st,
                             input logic use_typed, input xrmp_pkg::rec_t typed_rec);
        logic fired;
        xrmp_pkg::rec_t r;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.code_byte  <= cb;
        in_ch.start_flag <= st;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predecode_byte(cb, st, fired, r);
        if (fired)
            pending_records.push_back(use_typed ? typed_rec : r);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_known_op();
        logic [7:0] op;
        do
            op = 8'($urandom_range(0, 255));
        while (insn_class(op, 8'h00) == xrmp_pkg::MN_UNKNOWN);
        return op;
    endfunction

    // One random instruction: mostly well formed, some cut short or noise
    task automatic send_insn();
        int         kind;
        int         npfx;
        int         nopd;
        int         i;
        logic [7:0] op;
        logic [7:0] pfx;
        logic [7:0] modrm;
        logic       wide;
        logic       st;
        kind = $urandom_range(0, 99);
        st   = restart_next || ($urandom_range(0, 4) == 0);
        restart_next = 1'b0;
        wide = 1'b0;
        if (kind < 5)
        begin
            // prefix pile-up around the length limit
            npfx = $urandom_range(int'(xrmp_pkg::MAX_LENGTH) - 3,
                                  int'(xrmp_pkg::MAX_LENGTH) + 2);
            for (i = 0; i < npfx; i++)
                push_byte(prefix_by_index($urandom_range(0, 10)), (i == 0) && st, 1'b0, '0);
        end
        else if (kind < 12)
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        else
        begin
            npfx = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            for (i = 0; i < npfx; i++)
            begin
                pfx = prefix_by_index($urandom_range(0, 10));
                if (pfx == xrmp_pkg::PFX_OPSIZE)
                    wide = 1'b1;
                push_byte(pfx, (i == 0) && st, 1'b0, '0);
            end
            if ($urandom_range(0, 9) == 0)
                op = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 6) == 0)
                op = xrmp_pkg::OP_GRP5;
            else
                op = pick_known_op();
            push_byte(op, (npfx == 0) && st, 1'b0, '0);
            if (op == xrmp_pkg::OP_GRP5)
            begin
                modrm = 8'($urandom_range(0, 255));
                push_byte(modrm, 1'b0, 1'b0, '0);
                nopd = disp_bytes(modrm);
            end
            else
                nopd = imm_bytes(op, wide);
            // cut short: the next instruction restarts the decoder
            if (kind < 20 && nopd > 0)
            begin
                nopd = $urandom_range(0, nopd - 1);
                restart_next = 1'b1;
            end
            for (i = 0; i < nopd; i++)
                push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Record side: random ready, plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= snk_idle_pct);

    initial
    begin : rx_hold_off
        wait (hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : record_check
        xrmp_pkg::rec_t got;
        xrmp_pkg::rec_t want;
        string diffs;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.mnemonic_id   = out_ch.mnemonic_id;
            got.rep_seen      = out_ch.rep_seen;
            got.repne_seen    = out_ch.repne_seen;
            got.wide_operands = out_ch.wide_operands;
            got.reg_index     = out_ch.reg_index;
            got.operand_value = out_ch.operand_value;
            got.segment_value = out_ch.segment_value;
            got.branch_target = out_ch.branch_target;
            got.length        = out_ch.length;
            got.overlength    = out_ch.overlength;
            if (pending_records.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: record with none expected: %h", $realtime, got);
            end
            else
            begin
                want  = pending_records.pop_front();
                diffs = "";
                if (got.mnemonic_id != want.mnemonic_id)
                    diffs = {diffs, $sformatf(" mnemonic_id %0d/%0d",
                                              want.mnemonic_id, got.mnemonic_id)};
                if (got.rep_seen != want.rep_seen)
                    diffs = {diffs, $sformatf(" rep_seen %0b/%0b", want.rep_seen, got.rep_seen)};
                if (got.repne_seen != want.repne_seen)
                    diffs = {diffs, $sformatf(" repne_seen %0b/%0b",
                                              want.repne_seen, got.repne_seen)};
                if (got.wide_operands != want.wide_operands)
                    diffs = {diffs, $sformatf(" wide_operands %0b/%0b",
                                              want.wide_operands, got.wide_operands)};
                if (got.reg_index != want.reg_index)
                    diffs = {diffs, $sformatf(" reg_index %0d/%0d",
                                              want.reg_index, got.reg_index)};
                if (got.operand_value != want.operand_value)
                    diffs = {diffs, $sformatf(" operand_value %h/%h",
                                              want.operand_value, got.operand_value)};
                if (got.segment_value != want.segment_value)
                    diffs = {diffs, $sformatf(" segment_value %h/%h",
                                              want.segment_value, got.segment_value)};
                if (got.branch_target != want.branch_target)
                    diffs = {diffs, $sformatf(" branch_target %h/%h",
                                              want.branch_target, got.branch_target)};
                if (got.length != want.length)
                    diffs = {diffs, $sformatf(" length %0d/%0d", want.length, got.length)};
                if (got.overlength != want.overlength)
                    diffs = {diffs, $sformatf(" overlength %0b/%0b",
                                              want.overlength, got.overlength)};
                if (diffs != "")
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: record mismatch (exp/got):%s", $realtime, diffs);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        int guard;
        clear_decoder();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed rows
        add_row(xrmp_pkg::PFX_OPSIZE, 1'b0, 1'b0, '0);
        add_row(xrmp_pkg::PFX_REP, 1'b0, 1'b0, '0);
        add_row(xrmp_pkg::PFX_REPNE, 1'b0, 1'b0, '0);
        add_row(OPC_INSB, 1'b0, 1'b1, mk_rec(xrmp_pkg::MN_INSB, 3'b111, 4'd4, 1'b0));
        // every prefix kind, never an opcode: record cut at the limit
        for (i = 0; i < int'(xrmp_pkg::MAX_LENGTH); i++)
            add_row(prefix_by_index(i % 11), 1'b0, i == int'(xrmp_pkg::MAX_LENGTH) - 1,
                    mk_rec(xrmp_pkg::MN_UNKNOWN, 3'b111, xrmp_pkg::MAX_LENGTH, 1'b1));
        // partial MOV dropped by a restart on the FF opcode
        add_row(OPC_MOV_AX, 1'b0, 1'b0, '0);
        add_row(xrmp_pkg::OP_GRP5, 1'b1, 1'b0, '0);
        add_row(MODRM_CALL, 1'b0, 1'b0, '0);
        // far jump, offset 0000 segment FFFF
        add_row(OPC_JMP_FAR, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);

        src_idle_pct = 18;
        snk_idle_pct = 51;
        foreach (directed_rows[n])
            push_byte(directed_rows[n].cb, directed_rows[n].st,
                      directed_rows[n].use_typed, directed_rows[n].rec);

        while (bytes_sent < 330)
            send_insn();
        src_idle_pct = 51;
        snk_idle_pct = 18;
        while (bytes_sent < 630)
            send_insn();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_go = 1'b1;
        while (bytes_sent < 930)
            send_insn();
        in_ch.valid <= 1'b0;

        guard = 0;
        while (pending_records.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_records.size() != 0)
        begin
            fail_count++;
            $display("%0d expected records never arrived", pending_records.size());
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
